// ----- rtl/core/i64au_pkg.sv -----
package i64au_pkg;

   localparam int Width     = 64;
   localparam int DivStages = Width;
   // accept reg, operand prep, product sum, divider stages, output reg
   localparam int Latency   = DivStages + 4;

   localparam logic [2:0] MODE_ADD = 3'd0;
   localparam logic [2:0] MODE_SUB = 3'd1;
   localparam logic [2:0] MODE_MUL = 3'd2;
   localparam logic [2:0] MODE_DIV = 3'd3;
   localparam logic [2:0] MODE_REM = 3'd4;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_DIV_ZERO  = 2'd1;
   localparam logic [1:0] ST_MOD_ZERO  = 2'd2;
   localparam logic [1:0] ST_NOT_ARITH = 2'd3;

   // side info that rides along the divider stages
   typedef struct packed {
      logic [2:0]       mode;
      logic [1:0]       status;
      logic             neg_q;
      logic             neg_r;
      logic [Width-1:0] value;
   } side_type;

endpackage

// ----- rtl/core/int64_arith_unit.sv -----
// channel   ports                                   handshake
// request   req_mode, req_lhs, req_rhs              start, busy
// response  rsp_value, rsp_status                   rsp_valid strobe
//
// A word enters every cycle; busy stays low. Each result strobes on rsp_valid
// once its word has passed through the pipeline, which holds,
// in order: accept register, operand prep and partial products, product sum,
// 64 divider stages (one quotient bit each), output register.
// Synchronous reset clears only the valid bits.
// The receiver cannot stall, so nothing in the pipeline ever holds.
module int64_arith_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_mode,
   input  logic signed [63:0] req_lhs,
   input  logic signed [63:0] req_rhs,
   output logic        rsp_valid,
   output logic signed [63:0] rsp_value,
   output logic [1:0]  rsp_status
);
   localparam int W = i64au_pkg::Width;
   localparam int H = W / 2;

   assign busy = 1'b0;

   // stage A: accepted word
   logic         a_valid_ff;
   logic [2:0]   a_mode_ff;
   logic [W-1:0] a_lhs_ff, a_rhs_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= start & ~busy;
      end
      a_mode_ff <= req_mode;
      a_lhs_ff  <= req_lhs;
      a_rhs_ff  <= req_rhs;
   end

   // stage B: add/sub, partial products, magnitudes, status
   logic         b_valid_ff;
   logic [2:0]   b_mode_ff;
   logic [1:0]   b_status_ff;
   logic         b_neg_q_ff, b_neg_r_ff;
   logic [W-1:0] b_value_ff, b_pp_ll_ff, b_num_ff, b_den_ff;
   logic [H-1:0] b_pp_lh_ff, b_pp_hl_ff;

   logic [1:0]   b_status_in;
   logic [W-1:0] b_value_in;

   always_comb begin
      b_status_in = i64au_pkg::ST_OK;
      b_value_in  = '0;
      unique case (a_mode_ff)
         i64au_pkg::MODE_ADD: b_value_in = a_lhs_ff + a_rhs_ff;
         i64au_pkg::MODE_SUB: b_value_in = a_lhs_ff - a_rhs_ff;
         i64au_pkg::MODE_MUL: b_value_in = '0;
         i64au_pkg::MODE_DIV: begin
            if (a_rhs_ff == '0) b_status_in = i64au_pkg::ST_DIV_ZERO;
         end
         i64au_pkg::MODE_REM: begin
            if (a_rhs_ff == '0) b_status_in = i64au_pkg::ST_MOD_ZERO;
         end
         default: b_status_in = i64au_pkg::ST_NOT_ARITH;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else begin
         b_valid_ff <= a_valid_ff;
      end
      b_mode_ff   <= a_mode_ff;
      b_status_ff <= b_status_in;
      b_value_ff  <= b_value_in;
      b_neg_q_ff  <= a_lhs_ff[W-1] ^ a_rhs_ff[W-1];
      b_neg_r_ff  <= a_lhs_ff[W-1];
      b_num_ff    <= a_lhs_ff[W-1] ? (W'(0) - a_lhs_ff) : a_lhs_ff;
      b_den_ff    <= a_rhs_ff[W-1] ? (W'(0) - a_rhs_ff) : a_rhs_ff;
      b_pp_ll_ff  <= a_lhs_ff[H-1:0] * a_rhs_ff[H-1:0];
      b_pp_lh_ff  <= H'(a_lhs_ff[H-1:0] * a_rhs_ff[W-1:H]);
      b_pp_hl_ff  <= H'(a_lhs_ff[W-1:H] * a_rhs_ff[H-1:0]);
   end

   // stage C: product sum
   logic                c_valid_ff;
   i64au_pkg::side_type c_side_ff;
   logic [W-1:0]        c_num_ff, c_den_ff;
   logic [H-1:0]        c_cross;

   assign c_cross = b_pp_lh_ff + b_pp_hl_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else begin
         c_valid_ff <= b_valid_ff;
      end
      c_side_ff.mode   <= b_mode_ff;
      c_side_ff.status <= b_status_ff;
      c_side_ff.neg_q  <= b_neg_q_ff;
      c_side_ff.neg_r  <= b_neg_r_ff;
      c_side_ff.value  <= (b_mode_ff == i64au_pkg::MODE_MUL)
                        ? b_pp_ll_ff + {c_cross, {H{1'b0}}} : b_value_ff;
      c_num_ff <= b_num_ff;
      c_den_ff <= b_den_ff;
   end

   logic                d_valid;
   i64au_pkg::side_type d_side;
   logic [W-1:0]        d_quo, d_rem;

   i64au_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (c_valid_ff),
      .in_side   (c_side_ff),
      .in_num    (c_num_ff),
      .in_den    (c_den_ff),
      .out_valid (d_valid),
      .out_side  (d_side),
      .out_quo   (d_quo),
      .out_rem   (d_rem)
   );

   // output: sign fix and select
   logic [W-1:0] out_value_in;

   always_comb begin
      if (d_side.status != i64au_pkg::ST_OK) begin
         out_value_in = '0;
      end else if (d_side.mode == i64au_pkg::MODE_DIV) begin
         out_value_in = d_side.neg_q ? (W'(0) - d_quo) : d_quo;
      end else if (d_side.mode == i64au_pkg::MODE_REM) begin
         out_value_in = d_side.neg_r ? (W'(0) - d_rem) : d_rem;
      end else begin
         out_value_in = d_side.value;
      end
   end

   logic         rsp_valid_ff;
   logic [W-1:0] rsp_value_ff;
   logic [1:0]   rsp_status_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= d_valid;
      end
      rsp_value_ff  <= out_value_in;
      rsp_status_ff <= d_side.status;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_value  = rsp_value_ff;
   assign rsp_status = rsp_status_ff;
endmodule

// ----- rtl/core/i64au_div.sv -----
// Restoring unsigned divider, one quotient bit per stage.
module i64au_div (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   input  i64au_pkg::side_type      in_side,
   input  logic [i64au_pkg::Width-1:0] in_num,
   input  logic [i64au_pkg::Width-1:0] in_den,
   output logic                     out_valid,
   output i64au_pkg::side_type      out_side,
   output logic [i64au_pkg::Width-1:0] out_quo,
   output logic [i64au_pkg::Width-1:0] out_rem
);
   localparam int W = i64au_pkg::Width;
   localparam int N = i64au_pkg::DivStages;

   logic                valid_ff [0:N];
   i64au_pkg::side_type side_ff  [0:N];
   logic [W-1:0]        rem_ff   [0:N];
   logic [W-1:0]        quo_ff   [0:N];   // dividend bits shift out, quotient in
   logic [W-1:0]        den_ff   [0:N];

   assign valid_ff[0] = in_valid;
   assign side_ff[0]  = in_side;
   assign rem_ff[0]   = '0;
   assign quo_ff[0]   = in_num;
   assign den_ff[0]   = in_den;

   for (genvar i = 0; i < N; i++) begin : g_stage
      logic [W:0]   trial;
      logic [W:0]   diff;
      logic         ge;
      logic [W-1:0] rem_in;
      logic [W-1:0] quo_in;

      always_comb begin
         trial  = {rem_ff[i], quo_ff[i][W-1]};
         diff   = trial - {1'b0, den_ff[i]};
         ge     = ~diff[W];
         rem_in = ge ? diff[W-1:0] : trial[W-1:0];
         quo_in = {quo_ff[i][W-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i+1] <= 1'b0;
         end else begin
            valid_ff[i+1] <= valid_ff[i];
         end
         side_ff[i+1] <= side_ff[i];
         rem_ff[i+1]  <= rem_in;
         quo_ff[i+1]  <= quo_in;
         den_ff[i+1]  <= den_ff[i];
      end
   end

   assign out_valid = valid_ff[N];
   assign out_side  = side_ff[N];
   assign out_quo   = quo_ff[N];
   assign out_rem   = rem_ff[N];
endmodule

// ----- rtl/core/i64au_chk.sv -----
module i64au_chk (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic [2:0]  req_mode,
   input logic [63:0] req_lhs,
   input logic [63:0] req_rhs,
   input logic        rsp_valid,
   input logic [63:0] rsp_value,
   input logic [1:0]  rsp_status
);
   localparam int Lat = i64au_pkg::Latency;

   a_no_busy: assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("busy raised");

   a_zero_on_fault: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != i64au_pkg::ST_OK |-> rsp_value == '0)
      else $error("nonzero value with fault status");

   a_not_arith: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_mode > i64au_pkg::MODE_REM
      |-> ##Lat (rsp_valid && rsp_status == i64au_pkg::ST_NOT_ARITH))
      else $error("non-arithmetic word lost its status");

   a_add: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_mode == i64au_pkg::MODE_ADD
      |-> ##Lat (rsp_valid && rsp_value == $past(req_lhs + req_rhs, Lat)))
      else $error("add result wrong or late");

   a_div_zero: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_mode == i64au_pkg::MODE_DIV && req_rhs == '0
      |-> ##Lat (rsp_valid && rsp_status == i64au_pkg::ST_DIV_ZERO))
      else $error("divide by zero not flagged");
endmodule

bind int64_arith_unit i64au_chk u_chk (.*);

// ----- verif/int64_arith_unit_test.sv -----
module int64_arith_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [2:0]  mode;
      logic [63:0] lhs;
      logic [63:0] rhs;
   } op_word_type;

   typedef struct {
      logic [63:0] value;
      logic [1:0]  status;
   } result_word_type;

   localparam logic [2:0] MODE_NOP5 = 3'd5;
   localparam logic [2:0] MODE_NOP6 = 3'd6;
   localparam logic [2:0] MODE_NOP7 = 3'd7;
   localparam logic [63:0] MIN_S64 = 64'h8000_0000_0000_0000;
   localparam logic [63:0] MAX_S64 = 64'h7fff_ffff_ffff_ffff;
   localparam logic [63:0] NEG_ONE = '1;

   logic clock;
   logic reset;
   logic start;
   logic busy;
   logic [2:0] req_mode;
   logic signed [63:0] req_lhs;
   logic signed [63:0] req_rhs;
   logic rsp_valid;
   logic signed [63:0] rsp_value;
   logic [1:0] rsp_status;

   op_word_type     pending_ops[$];
   result_word_type expected_results[$];
   int mismatch_count = 0;
   int result_count = 0;
   int sender_idle_pct = 11;
   bit hold_sender = 0;
   bit stimulus_done = 0;
   int mode_seen[8];
   int div_zero_seen = 0;

   int64_arith_unit i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_mode(req_mode), .req_lhs(req_lhs), .req_rhs(req_rhs),
      .rsp_valid(rsp_valid), .rsp_value(rsp_value), .rsp_status(rsp_status)
   );

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   function automatic logic [63:0] abs64(logic [63:0] x);
      return x[63] ? 64'd0 - x : x;
   endfunction

   function automatic result_word_type compute_arith(op_word_type w);
      result_word_type r;
      logic [63:0] q, m;
      r.value = '0;
      r.status = i64au_pkg::ST_OK;
      q = '0;
      m = '0;
      if (w.rhs != 0) begin
         q = abs64(w.lhs) / abs64(w.rhs);
         m = abs64(w.lhs) % abs64(w.rhs);
         if (w.lhs[63] != w.rhs[63]) q = 64'd0 - q;
         if (w.lhs[63]) m = 64'd0 - m;
      end
      case (w.mode)
         i64au_pkg::MODE_ADD: r.value = w.lhs + w.rhs;
         i64au_pkg::MODE_SUB: r.value = w.lhs - w.rhs;
         i64au_pkg::MODE_MUL: r.value = w.lhs * w.rhs;
         i64au_pkg::MODE_DIV: begin
            if (w.rhs == 0) r.status = i64au_pkg::ST_DIV_ZERO;
            else r.value = q;
         end
         i64au_pkg::MODE_REM: begin
            if (w.rhs == 0) r.status = i64au_pkg::ST_MOD_ZERO;
            else r.value = m;
         end
         default: r.status = i64au_pkg::ST_NOT_ARITH;
      endcase
      return r;
   endfunction

   function automatic logic [63:0] random_operand();
      logic [63:0] v;
      case ($urandom_range(0, 9))
         0: v = MIN_S64;
         1: v = MAX_S64;
         2: v = NEG_ONE;
         3: v = '0;
         4: v = 64'(signed'($urandom_range(0, 40)) - 20);
         5: v = {32'(signed'(0) - $urandom_range(0, 1)), $urandom()};
         default: v = {$urandom(), $urandom()};
      endcase
      return v;
   endfunction

   task automatic push_op(logic [2:0] mode, logic [63:0] lhs, logic [63:0] rhs);
      op_word_type w;
      w.mode = mode;
      w.lhs = lhs;
      w.rhs = rhs;
      pending_ops.push_back(w);
   endtask

   // driver
   always @(posedge clock) begin
      op_word_type w;
      if (reset) begin
         start <= 0;
      end else begin
         if (start && !busy) begin
            w.mode = req_mode;
            w.lhs = req_lhs;
            w.rhs = req_rhs;
            expected_results.push_back(compute_arith(w));
            mode_seen[req_mode]++;
            if (req_rhs == 0 && (req_mode == i64au_pkg::MODE_DIV ||
                                 req_mode == i64au_pkg::MODE_REM))
               div_zero_seen++;
         end
         if (start && busy) begin
            // word still pending, keep it up
         end else if (pending_ops.size() > 0 && !hold_sender &&
                      $urandom_range(0, 99) >= sender_idle_pct) begin
            w = pending_ops.pop_front();
            start <= 1;
            req_mode <= w.mode;
            req_lhs <= w.lhs;
            req_rhs <= w.rhs;
         end else begin
            start <= 0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      result_word_type e;
      if (!reset && rsp_valid) begin
         result_count++;
         if (expected_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected result value=%h status=%0d", rsp_value, rsp_status);
         end else begin
            e = expected_results.pop_front();
            if (rsp_value !== e.value || rsp_status !== e.status) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: expected value=%h status=%0d, got value=%h status=%0d",
                           e.value, e.status, rsp_value, rsp_status);
            end
         end
      end
   end

   initial begin
      logic [63:0] lhs, rhs;
      logic [2:0] mode;
      start = 0;
      req_mode = '0;
      req_lhs = '0;
      req_rhs = '0;
      reset = 1;
      repeat (4) @(posedge clock);
      reset <= 0;

      // directed: extremes, every mode, zero divisors, min / -1
      push_op(i64au_pkg::MODE_ADD, MAX_S64, 64'd1);
      push_op(i64au_pkg::MODE_ADD, MIN_S64, NEG_ONE);
      push_op(i64au_pkg::MODE_SUB, MIN_S64, 64'd1);
      push_op(i64au_pkg::MODE_SUB, MAX_S64, NEG_ONE);
      push_op(i64au_pkg::MODE_MUL, MAX_S64, MAX_S64);
      push_op(i64au_pkg::MODE_MUL, MIN_S64, NEG_ONE);
      push_op(i64au_pkg::MODE_MUL, NEG_ONE, NEG_ONE);
      push_op(i64au_pkg::MODE_DIV, MIN_S64, NEG_ONE);
      push_op(i64au_pkg::MODE_REM, MIN_S64, NEG_ONE);
      push_op(i64au_pkg::MODE_DIV, 64'd7, 64'd0);
      push_op(i64au_pkg::MODE_REM, 64'd7, 64'd0);
      push_op(i64au_pkg::MODE_DIV, 64'd0 - 64'd7, 64'd2);
      push_op(i64au_pkg::MODE_REM, 64'd0 - 64'd7, 64'd2);
      push_op(i64au_pkg::MODE_DIV, 64'd7, 64'd0 - 64'd2);
      push_op(i64au_pkg::MODE_REM, 64'd7, 64'd0 - 64'd2);
      push_op(i64au_pkg::MODE_DIV, MAX_S64, MIN_S64);
      push_op(i64au_pkg::MODE_REM, MIN_S64, MAX_S64);
      push_op(i64au_pkg::MODE_DIV, 64'd1, 64'd1);
      push_op(MODE_NOP5, MAX_S64, MIN_S64);
      push_op(MODE_NOP6, NEG_ONE, NEG_ONE);
      push_op(MODE_NOP7, 64'd0, 64'd0);

      for (int i = 0; i < 1700; i++) begin
         if (i == 570) sender_idle_pct = 65;
         if (i == 1140) sender_idle_pct = 0;
         if (i == 850) begin
            // drain fully once before continuing
            wait (pending_ops.size() == 0);
            hold_sender = 1;
            wait (expected_results.size() == 0 && !start);
            hold_sender = 0;
         end
         mode = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7))
                                            : 3'($urandom_range(0, 4));
         lhs = random_operand();
         rhs = random_operand();
         while (pending_ops.size() > 8) @(posedge clock);
         push_op(mode, lhs, rhs);
      end

      wait (pending_ops.size() == 0);
      @(posedge clock);
      while (start) @(posedge clock);
      wait (expected_results.size() == 0);
      repeat (i64au_pkg::Latency + 10) @(posedge clock);
      $display("covered %0d results; per mode add %0d sub %0d mul %0d div %0d rem %0d",
               result_count, mode_seen[i64au_pkg::MODE_ADD],
               mode_seen[i64au_pkg::MODE_SUB], mode_seen[i64au_pkg::MODE_MUL],
               mode_seen[i64au_pkg::MODE_DIV], mode_seen[i64au_pkg::MODE_REM]);
      $display("non-arithmetic words %0d, zero divisors %0d, mismatches %0d",
               mode_seen[MODE_NOP5] + mode_seen[MODE_NOP6] + mode_seen[MODE_NOP7],
               div_zero_seen, mismatch_count);
      if (mismatch_count == 0 && expected_results.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin
      #200us;
      $display("timeout");
      $display("*** FAILED ***");
      $finish;
   end

endmodule
